>>> rtl/core/complex_poly_from_roots_top_assert.svh
// assertion macros for the checker file of the polynomial expansion block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef COMPLEX_POLY_FROM_ROOTS_TOP_ASSERT_SVH
`define COMPLEX_POLY_FROM_ROOTS_TOP_ASSERT_SVH

// same-cycle implication
`define CPFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpfr assertion failed");

// next-cycle implication
`define CPFR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpfr assertion failed");

`endif

>>> rtl/core/cpfr_pkg.sv
// shared constants and types for the complex polynomial expansion block
// used by cpfr_cell, complex_poly_from_roots_top, cpfr_checker and the testbench
package cpfr_pkg;

   localparam int COEF_W         = 64;
   localparam int CFRAC          = 36;
   localparam int DIGIT_W        = 16;
   localparam int NUM_DIGITS     = COEF_W / DIGIT_W;
   localparam int DIG_SEL_W      = 2;
   localparam int STEP_W         = 3;
   localparam int ROOT_FIELD_W   = 32;
   localparam int DEG_W          = 5;
   localparam int INDEX_W        = 5;
   localparam int REQ_DATA_W     = 2 * ROOT_FIELD_W;
   localparam int RSP_FIELDS_W   = 2 * COEF_W + INDEX_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W      = RSP_DATA_W - RSP_FIELDS_W;
   localparam int DEF_MAX_DEGREE = 16;
   localparam int DEF_ROOT_WIDTH = 32;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                 init;       // first root of a run: load start values
      logic                 mul_en;     // form digit products
      logic                 acc_en;     // fold digit products into accumulators
      logic                 acc_first;  // first fold starts from zero
      logic                 rnd_en;     // round and saturate accumulators
      logic                 upd_en;     // add lower neighbor and store
      logic                 shift_en;   // take upper neighbor (output burst)
      logic [DIG_SEL_W-1:0] dig_sel;    // coefficient digit for this product step
   } cell_cmd_type;

endpackage

>>> rtl/core/cpfr_cell.sv
// one complex coefficient cell: holds c[j], multiplies it by -r digit-serially
// and adds the lower neighbor; depends on cpfr_pkg
module cpfr_cell #(
   parameter int ROOT_WIDTH = cpfr_pkg::DEF_ROOT_WIDTH,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cpfr_pkg::cell_cmd_type             cmd,
   input  logic signed [ROOT_WIDTH:0]         neg_re,
   input  logic signed [ROOT_WIDTH:0]         neg_im,
   input  logic        [cpfr_pkg::COEF_W-1:0] init_re,
   input  logic        [cpfr_pkg::COEF_W-1:0] init_im,
   input  logic        [cpfr_pkg::COEF_W-1:0] prev_re,
   input  logic        [cpfr_pkg::COEF_W-1:0] prev_im,
   input  logic        [cpfr_pkg::COEF_W-1:0] next_re,
   input  logic        [cpfr_pkg::COEF_W-1:0] next_im,
   output logic        [cpfr_pkg::COEF_W-1:0] coef_re,
   output logic        [cpfr_pkg::COEF_W-1:0] coef_im,
   output logic                               ovf
);
   import cpfr_pkg::*;

   localparam int RF     = ROOT_WIDTH - 2;
   localparam int PRD_W  = DIGIT_W + 1 + ROOT_WIDTH + 1;
   localparam int ACC_W  = COEF_W + ROOT_WIDTH + 2;
   localparam int TOP_W  = ACC_W - COEF_W + 1;
   localparam logic [ACC_W-1:0]  HALF    = ACC_W'(1) << (RF - 1);
   localparam logic [COEF_W-1:0] ONE     = COEF_W'(1) << CFRAC;
   localparam logic [COEF_W-1:0] MAX_POS = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] MIN_NEG = {1'b1, {(COEF_W-1){1'b0}}};

   logic        [COEF_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PRD_W-1:0]  p_ar_ff, p_ar_in, p_bi_ff, p_bi_in;
   logic signed [PRD_W-1:0]  p_ai_ff, p_ai_in, p_br_ff, p_br_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic        [COEF_W-1:0] prd_re_ff, prd_re_in, prd_im_ff, prd_im_in;
   logic                     ovf_ff, ovf_in;

   logic        [DIGIT_W-1:0] dig_a, dig_b;
   logic signed [DIGIT_W:0]   sd_a, sd_b;
   logic                      top_dig;
   logic signed [ACC_W-1:0]   rs_re, rs_im, sh_re, sh_im;
   logic        [TOP_W-1:0]   hi_re, hi_im;
   logic                      rsat_re, rsat_im;
   logic        [COEF_W-1:0]  rnd_re, rnd_im;
   logic        [COEF_W-1:0]  sum_re, sum_im, add_re, add_im;
   logic                      asat_re, asat_im;
   logic        [COEF_W-1:0]  ld_re, ld_im;

   // signed top digit, unsigned lower digits
   always_comb begin
      dig_a   = re_ff[cmd.dig_sel*DIGIT_W +: DIGIT_W];
      dig_b   = im_ff[cmd.dig_sel*DIGIT_W +: DIGIT_W];
      top_dig = (cmd.dig_sel == DIG_SEL_W'(NUM_DIGITS - 1));
      sd_a    = {top_dig & dig_a[DIGIT_W-1], dig_a};
      sd_b    = {top_dig & dig_b[DIGIT_W-1], dig_b};
      p_ar_in = sd_a * neg_re;
      p_bi_in = sd_b * neg_im;
      p_ai_in = sd_a * neg_im;
      p_br_in = sd_b * neg_re;
   end

   // top digit first, so each fold shifts the partial sum up by one digit
   always_comb begin
      acc_re_in = cmd.acc_first ? ACC_W'(0) : (acc_re_ff <<< DIGIT_W);
      acc_im_in = cmd.acc_first ? ACC_W'(0) : (acc_im_ff <<< DIGIT_W);
      acc_re_in = acc_re_in + ACC_W'(p_ar_ff) - ACC_W'(p_bi_ff);
      acc_im_in = acc_im_in + ACC_W'(p_ai_ff) + ACC_W'(p_br_ff);
   end

   // round to nearest, ties up, then saturate to the coefficient format
   always_comb begin
      rs_re   = acc_re_ff + HALF;
      rs_im   = acc_im_ff + HALF;
      sh_re   = rs_re >>> RF;
      sh_im   = rs_im >>> RF;
      hi_re   = sh_re[ACC_W-1:COEF_W-1];
      hi_im   = sh_im[ACC_W-1:COEF_W-1];
      rsat_re = !((&hi_re) || !(|hi_re));
      rsat_im = !((&hi_im) || !(|hi_im));
      rnd_re  = rsat_re ? (hi_re[TOP_W-1] ? MIN_NEG : MAX_POS) : sh_re[COEF_W-1:0];
      rnd_im  = rsat_im ? (hi_im[TOP_W-1] ? MIN_NEG : MAX_POS) : sh_im[COEF_W-1:0];
   end

   always_comb begin
      sum_re  = prev_re + prd_re_ff;
      sum_im  = prev_im + prd_im_ff;
      asat_re = (prev_re[COEF_W-1] == prd_re_ff[COEF_W-1]) &&
                (sum_re[COEF_W-1] != prev_re[COEF_W-1]);
      asat_im = (prev_im[COEF_W-1] == prd_im_ff[COEF_W-1]) &&
                (sum_im[COEF_W-1] != prev_im[COEF_W-1]);
      add_re  = asat_re ? (prev_re[COEF_W-1] ? MIN_NEG : MAX_POS) : sum_re;
      add_im  = asat_im ? (prev_im[COEF_W-1] ? MIN_NEG : MAX_POS) : sum_im;
   end

   // start values: c0 = -r, c1 = 1, the rest zero
   always_comb begin
      if (CELL_INDEX == 0) begin
         ld_re = init_re;
         ld_im = init_im;
      end else if (CELL_INDEX == 1) begin
         ld_re = ONE;
         ld_im = '0;
      end else begin
         ld_re = '0;
         ld_im = '0;
      end
   end

   always_comb begin
      re_in     = re_ff;
      im_in     = im_ff;
      prd_re_in = prd_re_ff;
      prd_im_in = prd_im_ff;
      ovf_in    = ovf_ff;
      if (cmd.init) begin
         re_in  = ld_re;
         im_in  = ld_im;
         ovf_in = 1'b0;
      end else if (cmd.upd_en) begin
         re_in  = add_re;
         im_in  = add_im;
         ovf_in = ovf_ff | asat_re | asat_im;
      end else if (cmd.shift_en) begin
         re_in = next_re;
         im_in = next_im;
      end
      if (cmd.rnd_en) begin
         prd_re_in = rnd_re;
         prd_im_in = rnd_im;
         ovf_in    = ovf_ff | rsat_re | rsat_im;
      end
   end

   always_ff @(posedge clock) begin
      re_ff     <= re_in;
      im_ff     <= im_in;
      prd_re_ff <= prd_re_in;
      prd_im_ff <= prd_im_in;
      if (cmd.mul_en) begin
         p_ar_ff <= p_ar_in;
         p_bi_ff <= p_bi_in;
         p_ai_ff <= p_ai_in;
         p_br_ff <= p_br_in;
      end
      if (cmd.acc_en) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff <= 1'b0;
      end else begin
         ovf_ff <= ovf_in;
      end
   end

   assign coef_re = re_ff;
   assign coef_im = im_ff;
   assign ovf     = ovf_ff;

endmodule

>>> rtl/core/complex_poly_from_roots_top.sv
// top level of the complex polynomial expansion block: sequencer, root register
// and a chain of MAX_DEGREE+1 cpfr_cell instances; depends on cpfr_pkg
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata: root_re, root_im
//  rsp      out  rsp_tvalid/tready    tdata: coef_re, coef_im, coef_index; tlast; tuser
//  csr      in   csr_wen              csr_wdata: degree
//
// first root of a run: transfer, load, check
// later roots: transfer, then the 16-bit digit-serial multiply in each cell
//   (4 digit products folded into the accumulator, then round, add and check)
// a finished run streams (roots taken + 1) results, one per cycle while rsp_tready is high
// reset is synchronous and needs no clearing pass; req_tready is low while a root
//   is worked on and during a burst, and rsp_tready low holds the burst in place
module complex_poly_from_roots_top #(
   parameter int MAX_DEGREE = cpfr_pkg::DEF_MAX_DEGREE,
   parameter int ROOT_WIDTH = cpfr_pkg::DEF_ROOT_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // root_re [31:0], root_im [63:32]
   input  logic [cpfr_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // coef_re [63:0], coef_im [127:64], coef_index [132:128], zero fill above
   output logic [cpfr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   // overflow [0]
   output logic                                   rsp_tuser,
   input  logic                                   csr_wen,
   input  logic [cpfr_pkg::DEG_W-1:0]             csr_wdata
);
   import cpfr_pkg::*;

   localparam int RF     = ROOT_WIDTH - 2;
   localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
   localparam int EFF_W  = (CNT_W > DEG_W) ? CNT_W : DEG_W;
   localparam int INIT_W = ROOT_WIDTH + CFRAC + 2;
   localparam logic [INIT_W-1:0] INIT_HALF = INIT_W'(1) << (RF - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_DIGITS);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_RND  = 7'b0001000,
      ST_UPD  = 7'b0010000,
      ST_CHK  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [CNT_W-1:0]         roots_ff, roots_in;
   logic [CNT_W-1:0]         emit_ff, emit_in;
   logic                     ovf_ff, ovf_in;
   logic [DEG_W-1:0]         degree_ff;
   logic signed [ROOT_WIDTH:0] neg_re_ff, neg_re_in, neg_im_ff, neg_im_in;

   logic [2*REQ_DATA_W-1:0]  raw_re, raw_im;
   logic [ROOT_WIDTH-1:0]    root_re_v, root_im_v;
   logic signed [INIT_W-1:0] iw_re, iw_im, is_re, is_im;
   logic [COEF_W-1:0]        init_re, init_im;
   logic [EFF_W-1:0]         deg_x, eff, cnt_next;
   logic                     req_xfer, rsp_xfer, last_item;
   cell_cmd_type             cmd;

   logic [COEF_W-1:0]        cell_re [0:MAX_DEGREE];
   logic [COEF_W-1:0]        cell_im [0:MAX_DEGREE];
   logic [MAX_DEGREE:0]      cell_ovf;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_xfer  = rsp_tvalid && rsp_tready;
   assign last_item = (emit_ff == roots_ff);

   // low ROOT_WIDTH bits of the zero-extended field, taken as signed
   always_comb begin
      raw_re    = {{REQ_DATA_W{1'b0}}, {ROOT_FIELD_W{1'b0}}, req_tdata[ROOT_FIELD_W-1:0]};
      raw_im    = {{REQ_DATA_W{1'b0}}, {ROOT_FIELD_W{1'b0}},
                   req_tdata[REQ_DATA_W-1:ROOT_FIELD_W]};
      root_re_v = raw_re[ROOT_WIDTH-1:0];
      root_im_v = raw_im[ROOT_WIDTH-1:0];
      neg_re_in = (ROOT_WIDTH + 1)'(0) - {root_re_v[ROOT_WIDTH-1], root_re_v};
      neg_im_in = (ROOT_WIDTH + 1)'(0) - {root_im_v[ROOT_WIDTH-1], root_im_v};
   end

   // -r brought to the coefficient format, exact or rounded like a product
   always_comb begin
      iw_re   = (INIT_W'(neg_re_ff) <<< CFRAC) + INIT_HALF;
      iw_im   = (INIT_W'(neg_im_ff) <<< CFRAC) + INIT_HALF;
      is_re   = iw_re >>> RF;
      is_im   = iw_im >>> RF;
      init_re = COEF_W'(is_re);
      init_im = COEF_W'(is_im);
   end

   // register value zero acts as one, values above MAX_DEGREE are clamped to MAX_DEGREE
   always_comb begin
      deg_x    = EFF_W'(degree_ff);
      cnt_next = EFF_W'(roots_ff) + EFF_W'(1);
      if (deg_x == '0) begin
         eff = EFF_W'(1);
      end else if (deg_x > EFF_W'(MAX_DEGREE)) begin
         eff = EFF_W'(MAX_DEGREE);
      end else begin
         eff = deg_x;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      roots_in      = roots_ff;
      emit_in       = emit_ff;
      ovf_in        = ovf_ff;
      cmd           = '0;
      cmd.dig_sel   = DIG_SEL_W'(NUM_DIGITS - 1) - step_ff[DIG_SEL_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               step_in  = '0;
               state_in = (roots_ff == '0) ? ST_INIT : ST_MUL;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_CHK;
         end
         ST_MUL: begin
            cmd.mul_en    = (step_ff != LAST_STEP);
            cmd.acc_en    = (step_ff != '0);
            cmd.acc_first = (step_ff == STEP_W'(1));
            step_in       = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            cmd.rnd_en = 1'b1;
            state_in   = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd_en = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            ovf_in   = |cell_ovf;
            roots_in = CNT_W'(cnt_next);
            emit_in  = '0;
            state_in = (cnt_next >= eff) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               cmd.shift_en = 1'b1;
               if (last_item) begin
                  roots_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         roots_ff  <= '0;
         emit_ff   <= '0;
         ovf_ff    <= 1'b0;
         degree_ff <= DEG_W'(1);
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         roots_ff <= roots_in;
         emit_ff  <= emit_in;
         ovf_ff   <= ovf_in;
         if (csr_wen) begin
            degree_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         neg_re_ff <= neg_re_in;
         neg_im_ff <= neg_im_in;
      end
   end

   for (genvar j = 0; j <= MAX_DEGREE; j++) begin : g_cell
      logic [COEF_W-1:0] prv_re, prv_im, nxt_re, nxt_im;

      if (j == 0) begin : g_lo
         assign prv_re = '0;
         assign prv_im = '0;
      end else begin : g_lo
         assign prv_re = cell_re[j-1];
         assign prv_im = cell_im[j-1];
      end

      // the highest cell shifts in zero during a burst
      if (j == MAX_DEGREE) begin : g_hi
         assign nxt_re = '0;
         assign nxt_im = '0;
      end else begin : g_hi
         assign nxt_re = cell_re[j+1];
         assign nxt_im = cell_im[j+1];
      end

      cpfr_cell #(
         .ROOT_WIDTH (ROOT_WIDTH),
         .CELL_INDEX (j)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .neg_re  (neg_re_ff),
         .neg_im  (neg_im_ff),
         .init_re (init_re),
         .init_im (init_im),
         .prev_re (prv_re),
         .prev_im (prv_im),
         .next_re (nxt_re),
         .next_im (nxt_im),
         .coef_re (cell_re[j]),
         .coef_im (cell_im[j]),
         .ovf     (cell_ovf[j])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, INDEX_W'(emit_ff), cell_im[0], cell_re[0]};
   assign rsp_tlast  = last_item;
   assign rsp_tuser  = ovf_ff;

endmodule

>>> rtl/core/cpfr_checker.sv
// port-level checks for complex_poly_from_roots_top, attached by bind
// depends on cpfr_pkg and complex_poly_from_roots_top_assert.svh
`include "complex_poly_from_roots_top_assert.svh"

module cpfr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cpfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);
   import cpfr_pkg::*;

   logic rsp_xfer;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // a stalled result keeps its payload
   `CPFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // no root is taken while a burst is being delivered
   `CPFR_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)

   // a burst runs without gaps up to its last transfer
   `CPFR_ASSERT_NXT(a_burst_cont, clock, reset, rsp_xfer && !rsp_tlast,
      rsp_tvalid && $stable(rsp_tuser))

   // after the last transfer the block goes back to taking roots
   `CPFR_ASSERT_NXT(a_burst_end, clock, reset, rsp_xfer && rsp_tlast,
      !rsp_tvalid && req_tready)

endmodule

bind complex_poly_from_roots_top cpfr_checker u_cpfr_checker (.*);

>>> verif/poly_coef_monitor.sv
// watches the root, coefficient and degree ports of complex_poly_from_roots_top,
// predicts every coefficient transfer in fixed point and compares it field by field
// depends on cpfr_pkg
module poly_coef_monitor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // root_re [31:0], root_im [63:32]
   input  logic [cpfr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // coef_re [63:0], coef_im [127:64], coef_index [132:128], zero fill above
   input  logic [cpfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                rsp_tlast,
   // overflow [0]
   input  logic                                rsp_tuser,
   input  logic                                csr_wen,
   input  logic [cpfr_pkg::DEG_W-1:0]          csr_wdata,
   output int                                  error_count,
   output int                                  coefs_pending
);

   localparam int MAX_DEG       = cpfr_pkg::DEF_MAX_DEGREE;
   localparam int RFRAC         = cpfr_pkg::DEF_ROOT_WIDTH - 2;
   localparam int TO_COEF_SHIFT = cpfr_pkg::CFRAC - RFRAC;
   localparam int CW            = cpfr_pkg::COEF_W;
   localparam int IW            = cpfr_pkg::INDEX_W;
   localparam int RW            = cpfr_pkg::ROOT_FIELD_W;
   localparam int MAX_SHOWN     = 100;

   localparam logic signed [127:0] HALF_LSB  = 128'sd1 <<< (RFRAC - 1);
   localparam logic signed [63:0]  COEF_MAX  = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0]  COEF_MIN  = {1'b1, {63{1'b0}}};
   localparam logic signed [63:0]  COEF_ONE  = 64'sd1 <<< cpfr_pkg::CFRAC;

   typedef struct {
      logic signed [63:0] re;
      logic signed [63:0] im;
      logic [4:0]         index;
      logic               last;
      logic               ovf;
   } coef_rec_type;

   logic signed [63:0] cell_re [0:MAX_DEG];
   logic signed [63:0] cell_im [0:MAX_DEG];
   int                 roots_taken;
   bit                 run_ovf;
   logic [4:0]         degree_reg;
   coef_rec_type       expected_coefs [$];
   int                 err_total = 0;
   int                 shown = 0;

   assign error_count = err_total;

   task automatic note_error(input string msg);
      err_total++;
      if (shown < MAX_SHOWN) begin
         $display("%0t mismatch: %s", $time, msg);
         shown++;
      end
   endtask

   // round to nearest with ties up, drop the root fraction bits, saturate to 64 bits
   function automatic logic signed [63:0] round_prod(input logic signed [127:0] w);
      logic signed [127:0] q;
      q = (w + HALF_LSB) >>> RFRAC;
      if (q[127:63] != {65{q[63]}}) begin
         run_ovf = 1'b1;
         return q[127] ? COEF_MIN : COEF_MAX;
      end
      return q[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = a + b;
      if (s[64] != s[63]) begin
         run_ovf = 1'b1;
         return s[64] ? COEF_MIN : COEF_MAX;
      end
      return s[63:0];
   endfunction

   // multiply the stored polynomial by (x - r) and queue the coefficients when done
   task automatic absorb_root(input logic signed [31:0] re, input logic signed [31:0] im);
      logic signed [63:0]  nr, ni, pr, pi;
      logic signed [63:0]  nxt_re [0:MAX_DEG];
      logic signed [63:0]  nxt_im [0:MAX_DEG];
      logic signed [127:0] w;
      int                  eff, n, j;
      coef_rec_type        rec;
      nr = 64'sd0 - re;
      ni = 64'sd0 - im;
      eff = (degree_reg == 5'd0) ? 1 : int'(degree_reg);
      if (eff > MAX_DEG)
         eff = MAX_DEG;
      n = roots_taken;
      if (n == 0) begin
         for (j = 0; j <= MAX_DEG; j++) begin
            cell_re[j] = '0;
            cell_im[j] = '0;
         end
         run_ovf = 1'b0;
         cell_re[0] = nr <<< TO_COEF_SHIFT;
         cell_im[0] = ni <<< TO_COEF_SHIFT;
         cell_re[1] = COEF_ONE;
      end else begin
         for (j = 0; j <= n; j++) begin
            w  = cell_re[j] * nr - cell_im[j] * ni;
            pr = round_prod(w);
            w  = cell_re[j] * ni + cell_im[j] * nr;
            pi = round_prod(w);
            if (j == 0) begin
               nxt_re[0] = pr;
               nxt_im[0] = pi;
            end else begin
               nxt_re[j] = sat_sum(cell_re[j-1], pr);
               nxt_im[j] = sat_sum(cell_im[j-1], pi);
            end
         end
         nxt_re[n+1] = cell_re[n];
         nxt_im[n+1] = cell_im[n];
         for (j = 0; j <= n + 1; j++) begin
            cell_re[j] = nxt_re[j];
            cell_im[j] = nxt_im[j];
         end
      end
      roots_taken = n + 1;
      if (roots_taken >= eff) begin
         for (j = 0; j <= roots_taken; j++) begin
            rec.re    = cell_re[j];
            rec.im    = cell_im[j];
            rec.index = 5'(j);
            rec.last  = (j == roots_taken);
            rec.ovf   = run_ovf;
            expected_coefs.push_back(rec);
         end
         roots_taken = 0;
         run_ovf = 1'b0;
      end
   endtask

   task automatic check_coef();
      coef_rec_type                want;
      logic [63:0]                 got_re, got_im;
      logic [4:0]                  got_index;
      logic [cpfr_pkg::RSP_PAD_W-1:0] got_pad;
      got_re    = rsp_tdata[CW-1:0];
      got_im    = rsp_tdata[2*CW-1:CW];
      got_index = rsp_tdata[2*CW +: IW];
      got_pad   = rsp_tdata[cpfr_pkg::RSP_DATA_W-1 -: cpfr_pkg::RSP_PAD_W];
      if (expected_coefs.size() == 0) begin
         note_error($sformatf("coefficient transfer with none expected, index %0d",
                              got_index));
         return;
      end
      want = expected_coefs.pop_front();
      if (got_re !== want.re)
         note_error($sformatf("coef %0d re: got %h want %h", want.index, got_re, want.re));
      if (got_im !== want.im)
         note_error($sformatf("coef %0d im: got %h want %h", want.index, got_im, want.im));
      if (got_index !== want.index)
         note_error($sformatf("coef index: got %0d want %0d", got_index, want.index));
      if (rsp_tlast !== want.last)
         note_error($sformatf("coef %0d last: got %b want %b", want.index, rsp_tlast,
                              want.last));
      if (rsp_tuser !== want.ovf)
         note_error($sformatf("coef %0d overflow: got %b want %b", want.index, rsp_tuser,
                              want.ovf));
      if (got_pad !== '0)
         note_error($sformatf("coef %0d fill bits not zero: %b", want.index, got_pad));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= MAX_DEG; j++) begin
            cell_re[j] = '0;
            cell_im[j] = '0;
         end
         roots_taken = 0;
         run_ovf = 1'b0;
         degree_reg = 5'd1;
         expected_coefs.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_coef();
         if (req_tvalid && req_tready)
            absorb_root(req_tdata[RW-1:0], req_tdata[2*RW-1:RW]);
         if (csr_wen)
            degree_reg = csr_wdata;
      end
      coefs_pending <= expected_coefs.size();
   end

endmodule

>>> verif/tb_top.sv
// top of the polynomial expansion testbench: clock, reset, root and degree stimulus,
// coefficient receiver with random stalls; poly_coef_monitor does the checking
// depends on cpfr_pkg, complex_poly_from_roots_top and poly_coef_monitor
module tb_top;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int SETTLE       = 32;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 500;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [cpfr_pkg::REQ_DATA_W-1:0]    req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [cpfr_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tlast;
   logic                               rsp_tuser;
   logic                               csr_wen;
   logic [cpfr_pkg::DEG_W-1:0]         csr_wdata;
   int                                 error_count;
   int                                 coefs_pending;
   int                                 cycle_count = 0;
   bit                                 hold_arm = 1'b0;
   bit                                 steady = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   complex_poly_from_roots_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   poly_coef_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .coefs_pending (coefs_pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [31:0] pick_root();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h4000_0000;
            default: return 32'hc000_0000;
         endcase
      end
      if (r < 4)
         return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
      return $urandom;
   endfunction

   task automatic send_root(input logic [31:0] re, input logic [31:0] im);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 1) == 1)
         gap = stall_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {im, re};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // the block may still be multiplying a root that gives no coefficients
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (coefs_pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_degree(input logic [cpfr_pkg::DEG_W-1:0] d);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= d;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // receiver: random stalls, quiet stretches, and one long hold-off to back up the block
   initial begin : rsp_side
      int stall_left, hold_left, mode_left;
      bit quiet, hold_done;
      stall_left = 0;
      hold_left  = 0;
      mode_left  = 0;
      quiet      = 1'b0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            quiet = ($urandom_range(0, 2) == 0);
            mode_left = $urandom_range(40, 300);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_arm && !hold_done && rsp_tvalid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = stall_len() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int sent, phase, count;
      logic [cpfr_pkg::DEG_W-1:0] deg;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // degree 1 out of reset: zero root and both extremes
      send_root(32'h0000_0000, 32'h0000_0000);
      send_root(32'h7fff_ffff, 32'h7fff_ffff);
      send_root(32'h8000_0000, 32'h8000_0000);
      // degree register zero behaves as one
      set_degree(5'd0);
      send_root(32'hffff_ffff, 32'h0000_0001);
      set_degree(5'd2);
      send_root(32'h4000_0000, 32'hc000_0000);
      send_root(32'h8000_0000, 32'h7fff_ffff);
      // sixteen roots at -2-2i drive some coefficients into saturation
      set_degree(5'd16);
      repeat (16) send_root(32'h8000_0000, 32'h8000_0000);
      // lower the degree under a partly built run: the next root ends the run and emits it
      set_degree(5'd3);
      send_root(32'h1234_5678, 32'hedcb_a988);
      send_root(32'hc000_0001, 32'h3fff_ffff);
      set_degree(5'd1);
      send_root(32'h0000_0001, 32'hffff_ffff);

      hold_arm <= 1'b1;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: deg = 5'd4;
            1: deg = 5'd16;
            2: deg = 5'd0;
            3: deg = 5'd31;
            4: deg = 5'd1;
            5: deg = 5'd17;
            6: deg = 5'd2;
            default: begin
               count = $urandom_range(0, 19);
               if (count < 2)
                  deg = cpfr_pkg::DEG_W'($urandom_range(9, 31));
               else if (count < 4)
                  deg = cpfr_pkg::DEG_W'($urandom_range(0, 1));
               else
                  deg = cpfr_pkg::DEG_W'($urandom_range(2, 8));
            end
         endcase
         set_degree(deg);
         steady = ($urandom_range(0, 3) == 0);
         count = $urandom_range(8, 40);
         repeat (count) begin
            send_root(pick_root(), pick_root());
            sent++;
         end
         phase++;
      end

      wait_idle();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
